[rtl/cpe_pkg.sv]
// Types and constants shared by the pair energy block.
package cpe_pkg;

    localparam int COORD_W  = 32;
    localparam int CHARGE_W = 16;
    localparam int ENERGY_W = 48;
    localparam int STATUS_W = 2;

    localparam int MAG_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int DIST_W  = 66;
    localparam int PROD_W  = 2 * CHARGE_W;
    localparam int PMAG_W  = PROD_W - 1;

    localparam int ROOT_W  = DIST_W / 2 + 16;
    localparam int CQ_W    = 43;
    localparam int CORE_D  = 39;
    localparam int Q1_W    = 128;
    localparam int Q2_W    = 104;
    localparam int Q3_W    = 80;
    localparam int Q4_W    = 56;
    localparam int SUM_W   = Q4_W + 2;

    localparam int CORE_LAT  = Q1_W + Q2_W + Q3_W + Q4_W;
    localparam int COUL_LAT  = ROOT_W + CQ_W;
    localparam int CDELAY    = CORE_LAT - COUL_LAT;

    localparam logic [STATUS_W-1:0] ST_EXACT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COINCIDE = 2'd2;

    localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0]  first_x;
        logic signed [COORD_W-1:0]  first_y;
        logic signed [COORD_W-1:0]  first_z;
        logic signed [CHARGE_W-1:0] first_charge;
        logic signed [COORD_W-1:0]  second_x;
        logic signed [COORD_W-1:0]  second_y;
        logic signed [COORD_W-1:0]  second_z;
        logic signed [CHARGE_W-1:0] second_charge;
    } in_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] pair_energy;
        logic [STATUS_W-1:0]        energy_status;
    } out_t;

    typedef struct packed {
        logic [DIST_W-1:0]        dist_sq;
        logic signed [PROD_W-1:0] charge_prod;
    } pair_t;

    typedef struct packed {
        logic coincide;
        logic close;
        logic core_en;
        logic neg;
    } side_t;

endpackage

[rtl/cpe_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module cpe_div #(
    parameter int DW = 39,
    parameter int QW = 56
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quo_out,
    output logic [DW-1:0] den_out
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] num_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] num_next [QW];
    logic [QW-1:0] quo_next [QW];
    logic [DW-1:0] rem_src [QW];
    logic [QW-1:0] num_src [QW];
    logic [QW-1:0] quo_src [QW];
    logic [DW-1:0] den_src [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        if (i == 0)
        begin : g_first
            assign rem_src[i] = rem_in;
            assign num_src[i] = num_in;
            assign quo_src[i] = '0;
            assign den_src[i] = den_in;
        end
        else
        begin : g_rest
            assign rem_src[i] = rem_reg[i-1];
            assign num_src[i] = num_reg[i-1];
            assign quo_src[i] = quo_reg[i-1];
            assign den_src[i] = den_reg[i-1];
        end
        assign trial       = {rem_src[i], num_src[i][QW-1]};
        assign diff        = trial - {1'b0, den_src[i]};
        assign ge          = trial >= {1'b0, den_src[i]};
        assign rem_next[i] = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign num_next[i] = {num_src[i][QW-2:0], 1'b0};
        assign quo_next[i] = {quo_src[i][QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i] <= rem_next[i];
                num_reg[i] <= num_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_src[i];
            end
        end
    end

    assign quo_out = quo_reg[QW-1];
    assign den_out = den_reg[QW-1];

endmodule

[rtl/cpe_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module cpe_sqrt #(
    parameter int RW = 49
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] rad_in,
    output logic [RW-1:0]   root_out
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW+1:0]   rem_next [RW];
    logic [RW-1:0]   root_next [RW];
    logic [2*RW-1:0] rad_next [RW];
    logic [RW+1:0]   rem_src  [RW];
    logic [RW-1:0]   root_src [RW];
    logic [2*RW-1:0] rad_src  [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;
        if (i == 0)
        begin : g_first
            assign rem_src[i]  = '0;
            assign root_src[i] = '0;
            assign rad_src[i]  = rad_in;
        end
        else
        begin : g_rest
            assign rem_src[i]  = rem_reg[i-1];
            assign root_src[i] = root_reg[i-1];
            assign rad_src[i]  = rad_reg[i-1];
        end
        assign cur          = {rem_src[i], rad_src[i][2*RW-1:2*RW-2]};
        assign trial        = {2'b00, root_src[i], 2'b01};
        assign diff         = cur - trial;
        assign ge           = cur >= trial;
        assign rem_next[i]  = ge ? diff[RW+1:0] : cur[RW+1:0];
        assign root_next[i] = {root_src[i][RW-2:0], ge};
        assign rad_next[i]  = {rad_src[i][2*RW-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
            end
        end
    end

    assign root_out = root_reg[RW-1];

endmodule

[rtl/cpe_fifo.sv]
// Short queue between the front and back parts.
module cpe_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cpe_pkg::pair_t wdata,
    input  logic          pop,
    output cpe_pkg::pair_t rdata,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cpe_pkg::pair_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = count_reg == CW'(DEPTH);
    assign empty = count_reg == '0;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/cpe_front.sv]
// Front part: takes pairs, forms squared distance and charge product.
module cpe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mode,
    input  logic           in_valid,
    output logic           in_stall,
    input  cpe_pkg::in_t   in_data,
    input  logic           q_full,
    output logic           q_push,
    output cpe_pkg::pair_t q_data
);

    localparam int MW = cpe_pkg::MAG_W;
    localparam int SW = cpe_pkg::SQ_W;

    logic          en;
    logic          s1_valid_reg, s2_valid_reg;
    logic [MW-1:0] mx_reg, my_reg, mz_reg;
    logic [MW-1:0] mx_next, my_next, mz_next;
    logic signed [cpe_pkg::PROD_W-1:0] p1_reg, p2_reg, p1_next;
    logic [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [MW-1:0] dx, dy, dz;

    assign en       = !s2_valid_reg || !q_full;
    assign in_stall = !en;
    assign q_push   = s2_valid_reg && !q_full;

    assign dx = MW'(in_data.first_x) - MW'(in_data.second_x);
    assign dy = MW'(in_data.first_y) - MW'(in_data.second_y);
    assign dz = MW'(in_data.first_z) - MW'(in_data.second_z);

    always_comb
    begin
        mx_next = dx[MW-1] ? MW'(-dx) : MW'(dx);
        my_next = dy[MW-1] ? MW'(-dy) : MW'(dy);
        mz_next = dz[MW-1] ? MW'(-dz) : MW'(dz);
        if (!mode)
        begin
            mz_next = '0;
        end
        p1_next = in_data.first_charge * in_data.second_charge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
            mz_reg <= mz_next;
            p1_reg <= p1_next;
            sx_reg <= mx_reg * mx_reg;
            sy_reg <= my_reg * my_reg;
            sz_reg <= mz_reg * mz_reg;
            p2_reg <= p1_reg;
        end
    end

    assign q_data.dist_sq     = cpe_pkg::DIST_W'(sx_reg + sy_reg + sz_reg);
    assign q_data.charge_prod = p2_reg;

endmodule

[rtl/cpe_back.sv]
// Back part: root, Coulomb and core divisions, sum and saturation.
module cpe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    output logic           q_pop,
    input  cpe_pkg::pair_t q_data,
    output logic           out_valid,
    input  logic           out_stall,
    output cpe_pkg::out_t  out_data
);

    localparam int LAT = cpe_pkg::CORE_LAT;
    localparam int RW  = cpe_pkg::ROOT_W;
    localparam int CD  = cpe_pkg::CORE_D;
    localparam int NW  = cpe_pkg::SUM_W;

    logic en;
    logic [cpe_pkg::DIST_W-1:0] s;
    cpe_pkg::side_t side_in;
    logic [cpe_pkg::PMAG_W-1:0] pmag_in;
    logic signed [cpe_pkg::PROD_W-1:0] pneg;

    logic                       v_reg    [LAT];
    cpe_pkg::side_t             side_reg [LAT];
    logic [cpe_pkg::PMAG_W-1:0] pm_reg   [RW];
    logic [cpe_pkg::CQ_W-1:0]   c_reg    [cpe_pkg::CDELAY];

    logic [RW-1:0] root;
    logic [RW-1:0] cden_unused;
    logic [cpe_pkg::CQ_W-1:0] cquo;
    logic [cpe_pkg::Q1_W-1:0] q1;
    logic [cpe_pkg::Q2_W-1:0] q2;
    logic [cpe_pkg::Q3_W-1:0] q3;
    logic [cpe_pkg::Q4_W-1:0] q4;
    logic [CD-1:0] d1, d2, d3, d4;

    logic                       out_valid_reg;
    cpe_pkg::out_t              out_data_reg, out_data_next;
    logic signed [NW-1:0]       core_s, coul_s, sum;
    cpe_pkg::side_t             side_o;

    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && !q_empty;
    assign s     = q_data.dist_sq;
    assign pneg  = -q_data.charge_prod;

    always_comb
    begin
        side_in.coincide = s == '0;
        side_in.close    = (s != '0) && (s <= cpe_pkg::DIST_W'(1 << 24));
        side_in.core_en  = s < (cpe_pkg::DIST_W'(1) << 39);
        side_in.neg      = q_data.charge_prod[cpe_pkg::PROD_W-1];
        pmag_in = side_in.neg ? pneg[cpe_pkg::PMAG_W-1:0]
                              : q_data.charge_prod[cpe_pkg::PMAG_W-1:0];
    end

    cpe_sqrt #(.RW(RW)) u_sqrt (
        .clk      (clk),
        .en       (en),
        .rad_in   ({s, 32'b0}),
        .root_out (root)
    );

    cpe_div #(.DW(RW), .QW(cpe_pkg::CQ_W)) u_coul (
        .clk     (clk),
        .en      (en),
        .rem_in  (RW'(pm_reg[RW-1][cpe_pkg::PMAG_W-1:3])),
        .num_in  ({pm_reg[RW-1][2:0], 40'b0}),
        .den_in  (root),
        .quo_out (cquo),
        .den_out (cden_unused)
    );

    cpe_div #(.DW(CD), .QW(cpe_pkg::Q1_W)) u_core1 (
        .clk     (clk),
        .en      (en),
        .rem_in  (CD'(1) << 24),
        .num_in  ('0),
        .den_in  (s[CD-1:0]),
        .quo_out (q1),
        .den_out (d1)
    );

    cpe_div #(.DW(CD), .QW(cpe_pkg::Q2_W)) u_core2 (
        .clk     (clk),
        .en      (en),
        .rem_in  (CD'(q1[cpe_pkg::Q1_W-1:cpe_pkg::Q2_W])),
        .num_in  (q1[cpe_pkg::Q2_W-1:0]),
        .den_in  (d1),
        .quo_out (q2),
        .den_out (d2)
    );

    cpe_div #(.DW(CD), .QW(cpe_pkg::Q3_W)) u_core3 (
        .clk     (clk),
        .en      (en),
        .rem_in  (CD'(q2[cpe_pkg::Q2_W-1:cpe_pkg::Q3_W])),
        .num_in  (q2[cpe_pkg::Q3_W-1:0]),
        .den_in  (d2),
        .quo_out (q3),
        .den_out (d3)
    );

    cpe_div #(.DW(CD), .QW(cpe_pkg::Q4_W)) u_core4 (
        .clk     (clk),
        .en      (en),
        .rem_in  (CD'(q3[cpe_pkg::Q3_W-1:cpe_pkg::Q4_W])),
        .num_in  (q3[cpe_pkg::Q4_W-1:0]),
        .den_in  (d3),
        .quo_out (q4),
        .den_out (d4)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= q_pop;
            for (int i = 1; i < LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            pm_reg[0] <= pmag_in;
            for (int i = 1; i < RW; i++)
            begin
                pm_reg[i] <= pm_reg[i-1];
            end
            c_reg[0] <= cquo;
            for (int i = 1; i < cpe_pkg::CDELAY; i++)
            begin
                c_reg[i] <= c_reg[i-1];
            end
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        side_o = side_reg[LAT-1];
        core_s = side_o.core_en ? NW'({d4[0] & 1'b0, q4}) : '0;
        coul_s = NW'(c_reg[cpe_pkg::CDELAY-1]);
        if (side_o.neg)
        begin
            coul_s = -coul_s;
        end
        sum = core_s + coul_s;
        out_data_next.pair_energy   = sum[cpe_pkg::ENERGY_W-1:0];
        out_data_next.energy_status = cpe_pkg::ST_EXACT;
        if (sum > NW'(cpe_pkg::E_MAX))
        begin
            out_data_next.pair_energy   = cpe_pkg::E_MAX;
            out_data_next.energy_status = cpe_pkg::ST_OVERFLOW;
        end
        else if (sum < NW'(cpe_pkg::E_MIN))
        begin
            out_data_next.pair_energy   = cpe_pkg::E_MIN;
            out_data_next.energy_status = cpe_pkg::ST_OVERFLOW;
        end
        if (side_o.coincide)
        begin
            out_data_next.pair_energy   = cpe_pkg::E_MAX;
            out_data_next.energy_status = cpe_pkg::ST_COINCIDE;
        end
        else if (side_o.close)
        begin
            out_data_next.pair_energy   = cpe_pkg::E_MAX;
            out_data_next.energy_status = cpe_pkg::ST_OVERFLOW;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/coulomb_soft_core_pair_energy_top.sv]
// Coulomb pair energy with r^-8 core: top level.
// Pipeline: 2 front stages, the queue, 368 back stages (four chained
// 128/104/80/56-bit core divisions) and one output register.
// Throughput: one item per clock while out_stall is low; the back pipeline
// advances whenever the output register can take a result.
// Reset clears all valid flags and the queue; mode_reg resets to 1 (3D).
module coulomb_soft_core_pair_energy_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  cpe_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output cpe_pkg::out_t out_data
);

    logic           mode_reg, mode_next;
    logic           q_push, q_pop, q_full, q_empty;
    cpe_pkg::pair_t q_wdata, q_rdata;

    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    cpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    cpe_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    cpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
